[rtl/tbcc_pkg.sv]
// Package for the touch button click classifier.
// Holds the time width, register indexes, reset values and shared types.
// Depends on nothing.
package tbcc_pkg;

    localparam int TIME_W  = 32;
    localparam int THR_W   = 31;
    localparam int MS_W    = 16;
    localparam int CFG_W   = THR_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP_MS   = CFG_IDX_W'(3);

    localparam logic [THR_W-1:0] RST_TOUCH_THRESHOLD = THR_W'(50);
    localparam logic [MS_W-1:0]  RST_DEBOUNCE_MS     = MS_W'(50);
    localparam logic [MS_W-1:0]  RST_LONG_PRESS_MS   = MS_W'(2000);
    localparam logic [MS_W-1:0]  RST_DOUBLE_GAP_MS   = MS_W'(100);

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_LONG   = 2'd2,
        EV_DOUBLE = 2'd3
    } t_event;

    typedef struct packed {
        logic [THR_W-1:0] touch_threshold;
        logic [MS_W-1:0]  debounce_ms;
        logic [MS_W-1:0]  long_press_ms;
        logic [MS_W-1:0]  double_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic released;
        logic long_reported;
    } t_status;

endpackage

[rtl/tbcc_cfg.sv]
// Configuration register file of the touch button click classifier.
// Depends on tbcc_pkg for the register indexes, reset values and t_cfg.
module tbcc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbcc_pkg::CFG_W-1:0]     i_cfg_data,
    output tbcc_pkg::t_cfg                 o_cfg
);
    import tbcc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TOUCH_THRESHOLD: n_cfg.touch_threshold = i_cfg_data[THR_W-1:0];
                REG_DEBOUNCE_MS:     n_cfg.debounce_ms     = i_cfg_data[MS_W-1:0];
                REG_LONG_PRESS_MS:   n_cfg.long_press_ms   = i_cfg_data[MS_W-1:0];
                REG_DOUBLE_GAP_MS:   n_cfg.double_gap_ms   = i_cfg_data[MS_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.touch_threshold <= RST_TOUCH_THRESHOLD;
            r_cfg.debounce_ms     <= RST_DEBOUNCE_MS;
            r_cfg.long_press_ms   <= RST_LONG_PRESS_MS;
            r_cfg.double_gap_ms   <= RST_DOUBLE_GAP_MS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/tbcc_core.sv]
// Press, long press and release rules with the button state registers.
// Depends on tbcc_pkg for t_cfg, t_time, t_event and t_status.
module tbcc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_level,
    input  tbcc_pkg::t_time   i_now,
    input  tbcc_pkg::t_cfg    i_cfg,
    output tbcc_pkg::t_event  o_event,
    output tbcc_pkg::t_status o_status
);
    import tbcc_pkg::*;

    t_time  r_last_edge_ms, n_last_edge_ms;
    t_time  r_press_start_ms, n_press_start_ms;
    t_time  r_last_release_ms, n_last_release_ms;
    logic   r_prior_level, n_prior_level;
    logic   r_released, n_released;
    logic   r_long_reported, n_long_reported;
    t_event n_event;

    t_time since_edge;
    t_time since_press;
    t_time gap;
    logic  edge_ok;
    logic  long_ok;
    logic  double_ok;

    // Differences wrap modulo the time width.
    assign since_edge  = i_now - r_last_edge_ms;
    assign since_press = i_now - r_press_start_ms;
    assign gap         = r_press_start_ms - r_last_release_ms;
    assign edge_ok     = since_edge > TIME_W'(i_cfg.debounce_ms);
    assign long_ok     = since_press > TIME_W'(i_cfg.long_press_ms);
    assign double_ok   = gap < TIME_W'(i_cfg.double_gap_ms);

    always_comb begin
        n_last_edge_ms    = r_last_edge_ms;
        n_press_start_ms  = r_press_start_ms;
        n_last_release_ms = r_last_release_ms;
        n_prior_level     = r_prior_level;
        n_released        = r_released;
        n_long_reported   = r_long_reported;
        n_event           = EV_NONE;
        priority if (i_level && r_released && edge_ok) begin
            n_press_start_ms = i_now;
            n_last_edge_ms   = i_now;
            n_released       = 1'b0;
        end else if (i_level && !r_released && !r_long_reported && long_ok) begin
            n_long_reported = 1'b1;
            n_event         = EV_LONG;
        end else if (!i_level && !r_released && edge_ok) begin
            n_released     = 1'b1;
            n_last_edge_ms = i_now;
            if (r_long_reported) begin
                n_long_reported = 1'b0;
            end else begin
                n_event           = double_ok ? EV_DOUBLE : EV_CLICK;
                n_last_release_ms = i_now;
            end
        end else begin
            if (i_level != r_prior_level) begin
                n_last_edge_ms = i_now;
                n_prior_level  = i_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge_ms    <= '0;
            r_press_start_ms  <= '0;
            r_last_release_ms <= '0;
            r_prior_level     <= 1'b0;
            r_released        <= 1'b1;
            r_long_reported   <= 1'b0;
        end else if (i_advance) begin
            r_last_edge_ms    <= n_last_edge_ms;
            r_press_start_ms  <= n_press_start_ms;
            r_last_release_ms <= n_last_release_ms;
            r_prior_level     <= n_prior_level;
            r_released        <= n_released;
            r_long_reported   <= n_long_reported;
        end
    end

    assign o_event                = n_event;
    assign o_status.released      = r_released;
    assign o_status.long_reported = r_long_reported;

endmodule

[rtl/touch_button_click_classifier.sv]
// Top level of the touch button click classifier: input register, rules, result register.
// Depends on tbcc_pkg, tbcc_cfg and tbcc_core.
//
// Each sample (sensor count and millisecond timestamp) yields exactly one event code.
// A sample is taken into an input register, where its count has already been compared
// with the touch threshold; the press and release rules then run on it and the event goes
// to a result register, which waits while the output is stalled. A new sample is accepted
// in every cycle while the output is not stalled. Registers are to be written through a
// plain write port only while the block is idle; the block itself does not enforce this.
module touch_button_click_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tbcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tbcc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [31:0]             i_sensor_count,
    input  logic [31:0]                    i_now_ms,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [1:0]                     o_event_code
);
    import tbcc_pkg::*;

    t_cfg    cfg;
    t_event  core_event;
    t_status status;

    logic   r_in_valid;
    logic   r_level;
    t_time  r_now;
    logic   r_out_valid;
    t_event r_out_event;

    logic advance;
    logic in_xfer;
    logic level;

    tbcc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Negative counts never count as touched.
    assign level   = !i_sensor_count[31] && (i_sensor_count[30:0] > cfg.touch_threshold);
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_level <= level;
            r_now   <= TIME_W'(i_now_ms);
        end
    end

    tbcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_level  (r_level),
        .i_now    (r_now),
        .i_cfg    (cfg),
        .o_event  (core_event),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= core_event;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_code = r_out_event;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("processed sample produced no result");

    a_long_marks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && core_event == EV_LONG |=> status.long_reported)
        else $error("long press reported without recording it");

    a_click_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (core_event == EV_CLICK || core_event == EV_DOUBLE) |=> status.released)
        else $error("click reported while the button is still held");

    a_long_implies_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.long_reported |-> !status.released)
        else $error("long press flag set while released");

endmodule
